### rtl/tpt_pkg.sv
// Package for the tribble port transmitter: types, codes and constants.
// No dependencies; used by every module under rtl/.
package tpt_pkg;

	localparam int unsigned LIMIT_W = 24;
	localparam int unsigned PINS_W  = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ERR_W   = 2;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned PADDR_W = 2;
	localparam int unsigned PDATA_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50000);
	localparam logic [PINS_W-1:0]  PIN_BUSY    = 5'h08;
	localparam logic [PINS_W-1:0]  PIN_STROBE  = 5'h10;
	localparam logic [IDX_W-1:0]   LAST_TRIB   = 2'd2;

	// register map (byte addresses)
	localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = 2'd0;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_WAIT_LOW = 2'd1,
		PH_WAIT_ACK = 2'd2
	} phase_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 2'd0,
		ERR_BUSY_LOW = 2'd1,
		ERR_ACK      = 2'd2
	} err_t;

	typedef enum logic {
		CMD_POLL  = 1'b0,
		CMD_START = 1'b1
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic [PINS_W-1:0] pins;
		logic              done;
		err_t              err;
		logic              idle;
	} res_t;

endpackage

### rtl/tpt_regs.sv
// Configuration register file (APB-style) for the tribble port transmitter.
// Depends on tpt_pkg.
module tpt_regs
	import tpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [LIMIT_W-1:0] timeout_limit
);

	logic [LIMIT_W-1:0] limit_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr == ADDR_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_TIMEOUT) begin
			prdata = {{(PDATA_W-LIMIT_W){1'b0}}, limit_q};
		end
	end

	assign timeout_limit = limit_q;

endmodule

### rtl/tpt_core.sv
// Handshake sequencer: phase, tribble shifter, poll counter and pin register.
// Depends on tpt_pkg. Produces the result of the beat being accepted.
module tpt_core
	import tpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               command,
	input  logic [BYTE_W-1:0]  byte_value,
	input  logic               busy_in,
	input  logic [LIMIT_W-1:0] timeout_limit,
	output res_t               res
);

	phase_t             phase_q, phase_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [BYTE_W-1:0]  shift_q, shift_d;
	logic [LIMIT_W-1:0] count_q, count_d;
	logic [PINS_W-1:0]  pins_q, pins_d;
	logic               done;
	err_t               err;
	logic               expired;

	assign expired = (count_q >= timeout_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			shift_q <= '0;
			count_q <= '0;
			pins_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			count_q <= count_d;
			pins_q  <= pins_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		shift_d = shift_q;
		count_d = count_q;
		pins_d  = pins_q;
		done    = 1'b0;
		err     = ERR_NONE;
		case (phase_q)
			PH_WAIT_LOW: begin
				if (command == CMD_POLL) begin
					if (!busy_in) begin
						pins_d  = {2'b00, shift_q[2:0]} | PIN_STROBE;
						count_d = '0;
						phase_d = PH_WAIT_ACK;
					end else if (expired) begin
						err     = ERR_BUSY_LOW;
						phase_d = PH_IDLE;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
			end
			PH_WAIT_ACK: begin
				if (command == CMD_POLL) begin
					if (busy_in) begin
						pins_d  = PIN_BUSY;
						count_d = '0;
						if (idx_q >= LAST_TRIB) begin
							done    = 1'b1;
							idx_d   = '0;
							phase_d = PH_IDLE;
						end else begin
							idx_d   = idx_q + 1'b1;
							shift_d = shift_q >> 3;
							phase_d = PH_WAIT_LOW;
						end
					end else if (expired) begin
						err     = ERR_ACK;
						phase_d = PH_IDLE;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (command == CMD_START) begin
					shift_d = byte_value;
					idx_d   = '0;
					count_d = '0;
					pins_d  = PIN_BUSY;
					phase_d = PH_WAIT_LOW;
				end
			end
		endcase
		res.pins = pins_d;
		res.done = done;
		res.err  = err;
		res.idle = (phase_d == PH_IDLE);
	end

endmodule

### rtl/tpt_outreg.sv
// Result register with valid/ready handshake for the tribble port transmitter.
// Depends on tpt_pkg.
module tpt_outreg
	import tpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res,
	input  logic out_ready,
	output logic out_valid,
	output logic hold,
	output res_t res_q
);

	logic valid_q;

	// full and not being drained
	assign hold      = valid_q & ~out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

### rtl/tribble_port_transmitter.sv
// Top level of the tribble port transmitter.
// Depends on tpt_pkg, tpt_regs, tpt_core and tpt_outreg.
//
// Channel   Handshake               Beat contents
// input     in_valid / in_ready     command, byte_value, busy_in
// output    out_valid / out_ready   data_pins, byte_done, error_code, ready_res
// config    psel/penable/pready     paddr, pwdata, prdata (timeout_limit at 0x0)
//
// One beat per clock while in_ready is high: the sequencer state updates at
// the edge that accepts an input beat and the matching result is loaded into
// the result register there, so out_valid rises in the cycle after acceptance.
// in_ready drops only while the result register is full and out_ready is low.
// arst_n clears phase (idle), counters, pin register and the result valid.
module tribble_port_transmitter
	import tpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [BYTE_W-1:0]  byte_value,
	input  logic               busy_in,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PINS_W-1:0]  data_pins,
	output logic               byte_done,
	output logic [ERR_W-1:0]   error_code,
	output logic               ready_res,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [LIMIT_W-1:0] timeout_limit;
	logic               accept;
	logic               hold;
	res_t               res;
	res_t               res_q;

	// a new beat may enter whenever the result register is empty or is being drained this cycle
	assign in_ready = ~hold;
	assign accept   = in_valid & in_ready;

	tpt_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.timeout_limit(timeout_limit)
	);

	tpt_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.byte_value   (byte_value),
		.busy_in      (busy_in),
		.timeout_limit(timeout_limit),
		.res          (res)
	);

	tpt_outreg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.hold     (hold),
		.res_q    (res_q)
	);

	assign data_pins  = res_q.pins;
	assign byte_done  = res_q.done;
	assign error_code = res_q.err;
	assign ready_res  = res_q.idle;

endmodule
